### rtl/bat_pkg.sv
// shared types and constants for the breakpoint address table
// no dependencies; used by bat_cell and breakpoint_address_table_top
package bat_pkg;

  localparam int unsigned ADDR_W          = 16;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned CNT_OUT_W       = 5;
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned IN_TDATA_W      = 24;
  localparam int unsigned OUT_TDATA_W     = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_CHECK = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic              add;
    logic              clr;
    logic [ADDR_W-1:0] key;
  } cell_cmd_t;

endpackage

### rtl/bat_cell.sv
// one slot of the breakpoint table: address register, comparator, shift link
// depends on bat_pkg
module bat_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic                      clk_i,
  input  bat_pkg::cell_cmd_t        cmd_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic                      seen_i,
  input  logic [bat_pkg::ADDR_W-1:0] next_addr_i,
  output logic                      seen_o,
  output logic [bat_pkg::ADDR_W-1:0] addr_o
);
  import bat_pkg::*;

  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              valid;
  logic              hit;

  assign valid  = CNT_W'(IDX) < count_i;
  assign hit    = valid && (addr_q == cmd_i.key);
  assign seen_o = seen_i | hit;
  assign addr_o = addr_q;

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.add && (CNT_W'(IDX) == count_i)) begin
      addr_d = cmd_i.key;
    end else if (cmd_i.clr && seen_o && valid) begin
      addr_d = next_addr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

endmodule

### rtl/breakpoint_address_table_top.sv
// breakpoint address table top: row of bat_cell slots, entry count, result register
// depends on bat_pkg and bat_cell
//
// usage: items enter on the s_axis group (operation, address) and one result
// item per input leaves on the m_axis group (status, hit, entry_count,
// added_slot). every slot compares its address in parallel and a match flag
// ripples down the row of cells, so an item is decided in the cycle it is
// accepted and its result appears in the output register in the next cycle.
// throughput is one item per cycle while the receiver takes results; a clear
// shifts every later slot down by one from its neighbor in the same cycle.
// when the receiver stalls, the result waits in the output register and the
// input is held off until that result is taken or taken in the same cycle.
// reset empties the table (entry count zero) and drops any pending result;
// slot contents are not cleared since only slots below the count are compared.
module breakpoint_address_table_top #(
  parameter int unsigned MAX_ENTRIES = bat_pkg::MAX_ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // operation [1:0], address [17:2], zero [23:18]
  input  logic [bat_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // status [1:0], hit [2], entry_count [7:3], added_slot [12:8], zero [15:13]
  output logic [bat_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import bat_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  logic                   in_acc;
  logic [OP_W-1:0]        op_raw;
  logic [ADDR_W-1:0]      key;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   full, found;
  logic                   add_ok, clr_ok;
  cell_cmd_t              cmd;
  logic [MAX_ENTRIES:0]   seen;
  logic [ADDR_W-1:0]      addrs [MAX_ENTRIES];
  status_e                status;
  logic                   hit;
  logic [CNT_OUT_W-1:0]   slot;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign op_raw          = s_axis_tdata_i[OP_W-1:0];
  assign key             = s_axis_tdata_i[OP_W +: ADDR_W];

  assign full  = count_q >= CNT_W'(MAX_ENTRIES);
  assign found = seen[MAX_ENTRIES];

  assign seen[0] = 1'b0;

  generate
    for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
      logic [ADDR_W-1:0] nbr;
      if (j + 1 < MAX_ENTRIES) begin : g_mid
        assign nbr = addrs[j+1];
      end else begin : g_end
        assign nbr = addrs[j];
      end
      bat_cell #(
        .CNT_W (CNT_W),
        .IDX   (j)
      ) u_cell (
        .clk_i       (clk_i),
        .cmd_i       (cmd),
        .count_i     (count_q),
        .seen_i      (seen[j]),
        .next_addr_i (nbr),
        .seen_o      (seen[j+1]),
        .addr_o      (addrs[j])
      );
    end
  endgenerate

  always_comb begin
    status  = ST_OK;
    hit     = 1'b0;
    slot    = '0;
    add_ok  = 1'b0;
    clr_ok  = 1'b0;
    count_d = count_q;
    case (op_raw)
      OP_ADD: begin
        if (full) begin
          status = ST_FULL;
        end else if (found) begin
          status = ST_PRESENT;
        end else begin
          add_ok  = in_acc;
          slot    = CNT_OUT_W'(count_q + 1'b1);
        end
      end
      OP_CLEAR: begin
        if (found) begin
          clr_ok = in_acc;
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      OP_CHECK: begin
        hit = found;
      end
      default: begin
        status = ST_OK;
      end
    endcase
    if (add_ok) begin
      count_d = count_q + 1'b1;
    end else if (clr_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  assign cmd.add = add_ok;
  assign cmd.clr = clr_ok;
  assign cmd.key = key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= {3'b000, slot, CNT_OUT_W'(count_d), hit, status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(count_q))
    else $error("entry count changed without an item");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_ok |=> count_q == $past(count_q) + 1'b1)
    else $error("successful add did not grow the table");

  a_clear_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_ok |=> count_q == $past(count_q) - 1'b1)
    else $error("successful clear did not shrink the table");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> out_valid_q && !m_axis_tready_i)
    else $error("input held off without a stalled result");

endmodule

### tb/sv/breakpoint_table_checker.sv
`timescale 1ns / 100ps
// watches both stream groups of the breakpoint address table, predicts each result item
// and compares it field by field; depends on bat_pkg
module breakpoint_table_checker #(
  parameter int unsigned MAX_ENTRIES = bat_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [bat_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [bat_pkg::OUT_TDATA_W-1:0] out_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              item_count_o,
  output int                              result_count_o,
  output int                              hit_count_o,
  output int                              full_count_o
);
  import bat_pkg::*;

  typedef struct packed {
    status_e                status;
    logic                   hit;
    logic [CNT_OUT_W-1:0]   entry_count;
    logic [CNT_OUT_W-1:0]   added_slot;
  } table_result_t;

  logic [ADDR_W-1:0] bp_addr_q [MAX_ENTRIES];
  int unsigned       bp_count_q;
  table_result_t     expected_results_q [$];

  function automatic table_result_t apply_table_op(logic [OP_W-1:0] op,
                                                   logic [ADDR_W-1:0] addr);
    table_result_t res;
    int unsigned   pos;
    int unsigned   i;
    res.status      = ST_OK;
    res.hit         = 1'b0;
    res.added_slot  = '0;
    pos = bp_count_q;
    for (i = 0; i < bp_count_q; i++) begin
      if (bp_addr_q[i] == addr && pos == bp_count_q) begin
        pos = i;
      end
    end
    case (op)
      OP_ADD: begin
        if (bp_count_q >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else if (pos < bp_count_q) begin
          res.status = ST_PRESENT;
        end else begin
          bp_addr_q[bp_count_q] = addr;
          bp_count_q++;
          res.added_slot = CNT_OUT_W'(bp_count_q);
        end
      end
      OP_CLEAR: begin
        if (pos < bp_count_q) begin
          // later entries move down one slot
          for (i = pos; i + 1 < bp_count_q; i++) begin
            bp_addr_q[i] = bp_addr_q[i+1];
          end
          bp_count_q--;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_CHECK: begin
        res.hit = (pos < bp_count_q);
      end
      default: begin
      end
    endcase
    res.entry_count = CNT_OUT_W'(bp_count_q);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t exp_res;
    table_result_t got_res;
    if (!rst_ni) begin
      bp_count_q = 0;
      expected_results_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      item_count_o   = 0;
      result_count_o = 0;
      hit_count_o    = 0;
      full_count_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        exp_res = apply_table_op(in_data_i[OP_W-1:0], in_data_i[OP_W +: ADDR_W]);
        expected_results_q.push_back(exp_res);
        item_count_o++;
        if (exp_res.hit) begin
          hit_count_o++;
        end
        if (exp_res.status == ST_FULL) begin
          full_count_o++;
        end
      end
      if (out_valid_i && out_ready_i) begin
        result_count_o++;
        got_res.status      = status_e'(out_data_i[1:0]);
        got_res.hit         = out_data_i[2];
        got_res.entry_count = out_data_i[7:3];
        got_res.added_slot  = out_data_i[12:8];
        if (expected_results_q.size() == 0) begin
          $error("result item with nothing expected: tdata %h", out_data_i);
          fail_count_o++;
        end else begin
          exp_res = expected_results_q.pop_front();
          if (got_res.status != exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, got_res.status);
            fail_count_o++;
          end
          if (got_res.hit != exp_res.hit) begin
            $error("hit: expected %0d, actual %0d", exp_res.hit, got_res.hit);
            fail_count_o++;
          end
          if (got_res.entry_count != exp_res.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", exp_res.entry_count,
                   got_res.entry_count);
            fail_count_o++;
          end
          if (got_res.added_slot != exp_res.added_slot) begin
            $error("added_slot: expected %0d, actual %0d", exp_res.added_slot,
                   got_res.added_slot);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_results_q.size();
    end
  end

endmodule

### tb/sv/tb_breakpoint_address_table_top.sv
`timescale 1ns / 100ps
// top of the breakpoint address table testbench: clock, reset, items in, results out
// depends on bat_pkg, breakpoint_address_table_top and breakpoint_table_checker
module tb_breakpoint_address_table_top;
  import bat_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int              HOLD_CYCLES = 40;
  localparam int              CYCLE_LIMIT = 200000;
  localparam int              PHASES      = 12;
  localparam int              PHASE_ITEMS = 100;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int item_count;
  int result_count;
  int hit_count;
  int full_count;

  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_req  = 1'b0;
  int cycles    = 0;

  breakpoint_address_table_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  breakpoint_table_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_i     (s_axis_tready),
    .in_data_i      (s_axis_tdata),
    .out_valid_i    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_i     (m_axis_tdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .item_count_o   (item_count),
    .result_count_o (result_count),
    .hit_count_o    (hit_count),
    .full_count_o   (full_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-OP_W-ADDR_W){1'b0}}, addr, op};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  // result side: per-item stall, plus a long hold-off on request
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = recv_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk); while (!m_axis_tvalid);
      @(posedge clk);
    end
  end

  initial begin
    logic [ADDR_W-1:0] addr_pool [24];
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    int                pool_size;
    int                add_pct;
    int                clr_pct;
    int                roll;
    int                ph;
    int                k;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, unused code, add/duplicate/check/clear basics
    send_item(OP_CHECK, 16'h0000);
    send_item(OP_CLEAR, 16'hFFFF);
    send_item(OP_UNUSED, 16'hFFFF);
    send_item(OP_ADD, 16'h0000);
    send_item(OP_ADD, 16'hFFFF);
    send_item(OP_ADD, 16'h0000);
    send_item(OP_CHECK, 16'hFFFF);
    send_item(OP_CHECK, 16'h8000);
    send_item(OP_CLEAR, 16'h0000);
    send_item(OP_CHECK, 16'h0000);

    // fill to capacity back to back while the receiver holds off
    hold_req = 1'b1;
    for (k = 1; k < 16; k++) begin
      send_item(OP_ADD, ADDR_W'(k * 16'h1111 ^ 16'h5A5A));
    end
    send_item(OP_ADD, 16'h1234);
    send_item(OP_ADD, 16'hFFFF);
    send_item(OP_CLEAR, 16'hFFFF);
    send_item(OP_ADD, 16'h0000);
    send_item(OP_CHECK, 16'h0000);

    for (ph = 0; ph < PHASES; ph++) begin
      pool_size = (ph % 3 == 0) ? 4 : ((ph % 3 == 1) ? 12 : 24);
      for (k = 0; k < pool_size; k++) begin
        addr_pool[k] = ADDR_W'($urandom_range(0, 16'hFFFF));
      end
      // alternate between filling and draining the table
      add_pct = (ph % 2 == 0) ? 55 : 25;
      clr_pct = (ph % 2 == 0) ? 20 : 45;
      send_idle = (ph == 1) ? 1'b0 : ((ph == 2) ? 1'b1 : 1'($urandom_range(0, 1)));
      recv_idle = (ph == 1) ? 1'b0 : ((ph == 2) ? 1'b1 : 1'($urandom_range(0, 1)));
      if (ph == 5) begin
        send_idle = 1'b0;
        hold_req  = 1'b1;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
          op = OP_ADD;
        end else if (roll < add_pct + clr_pct) begin
          op = OP_CLEAR;
        end else if (roll < 95) begin
          op = OP_CHECK;
        end else begin
          op = OP_UNUSED;
        end
        if ($urandom_range(0, 99) < 75) begin
          addr = addr_pool[$urandom_range(0, pool_size - 1)];
        end else begin
          addr = ADDR_W'($urandom_range(0, 16'hFFFF));
        end
        send_item(op, addr);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);

    $display("ran %0d items through add, clear, check and the unused code", item_count);
    $display("compared %0d results: %0d check hits, %0d adds refused on a full table",
             result_count, hit_count, full_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
